FILE: hdl/csest_pkg.sv
// Package for the causal strength estimator: payload structs, job record, widths.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package csest_pkg;

  localparam int TIME_W = 64;
  localparam int ELEM_W = 16;
  localparam int CNT_W  = 13;
  localparam int ACC_W  = 43;
  localparam int DOT_W  = 44;
  localparam int PROD_W = 86;
  localparam int REM_W  = 87;
  localparam int QUO_W  = 31;
  localparam int FRAC_W = 15;
  localparam int STEP_W = 6;

  localparam logic [TIME_W-1:0] TW_RESET = 64'd1000;
  localparam logic [15:0]       Q_MAX    = 16'd32767;

  typedef struct packed {
    logic signed [ELEM_W-1:0] cause_element;
    logic signed [ELEM_W-1:0] effect_element;
    logic                     element_present;
    logic [TIME_W-1:0]        cause_time;
    logic [TIME_W-1:0]        effect_time;
    logic                     last_pair;
  } in_t;

  typedef struct packed {
    logic [15:0]        strength;
    logic signed [15:0] correlation;
    logic [15:0]        time_factor;
    logic               too_long;
  } out_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [ACC_W-1:0]        cause_norm;
    logic [ACC_W-1:0]        effect_norm;
    logic                    time_ok;
    logic [TIME_W-1:0]       lag;
    logic [TIME_W-1:0]       window;
    logic                    too_long;
  } job_t;

endpackage

FILE: hdl/csest_front.sv
// Front end: accepts element pairs, accumulates dot product and norms, owns the lag window.
// Emits one job per run on the last request. Depends on csest_pkg.
`timescale 1ns / 1ps
module csest_front import csest_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job_data
);

  logic signed [DOT_W-1:0] dot_r, dot_nxt;
  logic [ACC_W-1:0]        cn_r, cn_nxt, en_r, en_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [TIME_W-1:0]       tw_r;
  logic signed [31:0]      p_ce, p_cc, p_ee;
  logic                    take, add;
  logic [TIME_W-1:0]       lag;

  assign in_ready = job_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    p_ce = in_data.cause_element * in_data.effect_element;
    p_cc = in_data.cause_element * in_data.cause_element;
    p_ee = in_data.effect_element * in_data.effect_element;
    add  = in_data.element_present && (cnt_r < CNT_W'(MAX_LEN));
    dot_nxt = dot_r;
    cn_nxt  = cn_r;
    en_nxt  = en_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r || (in_data.element_present && !add);
    if (add) begin
      dot_nxt = dot_r + DOT_W'(p_ce);
      cn_nxt  = cn_r + ACC_W'(unsigned'(p_cc));
      en_nxt  = en_r + ACC_W'(unsigned'(p_ee));
      cnt_nxt = cnt_r + 1'b1;
    end
    lag = in_data.effect_time - in_data.cause_time;
    job_valid            = take && in_data.last_pair;
    job_data.dot         = dot_nxt;
    job_data.cause_norm  = cn_nxt;
    job_data.effect_norm = en_nxt;
    job_data.time_ok     = (in_data.effect_time > in_data.cause_time) && (lag <= tw_r);
    job_data.lag         = lag;
    job_data.window      = tw_r;
    job_data.too_long    = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      cn_r  <= '0;
      en_r  <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      tw_r  <= TW_RESET;
    end else begin
      if (cfg_we) begin
        tw_r <= cfg_wdata;
      end
      if (take) begin
        if (in_data.last_pair) begin
          dot_r <= '0;
          cn_r  <= '0;
          en_r  <= '0;
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          dot_r <= dot_nxt;
          cn_r  <= cn_nxt;
          en_r  <= en_nxt;
          cnt_r <= cnt_nxt;
          ovf_r <= ovf_nxt;
        end
      end
    end
  end

endmodule

FILE: hdl/csest_fifo.sv
// Two-entry job queue between front and back end.
// Depends on csest_pkg for the job record.
`timescale 1ns / 1ps
module csest_fifo import csest_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hdl/csest_back.sv
// Back end: sequencer with a shared shift-add multiplier, restoring divider and
// bit-serial square root; also the serial time factor divide. Depends on csest_pkg.
`timescale 1ns / 1ps
module csest_back import csest_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL_P = 6'b000010,
    S_MUL_S = 6'b000100,
    S_DIV   = 6'b001000,
    S_SQRT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  job_t                job_r;
  logic [PROD_W-1:0]   ma_r, acc_r, acc_add, p_r;
  logic [ACC_W-1:0]    mb_r;
  logic [STEP_W-1:0]   step_r;
  logic [REM_W-1:0]    rem_r, rem_sh;
  logic                feed_r;
  logic [QUO_W-1:0]    quo_r;
  logic [15:0]         root_r, root_try, mag;
  logic [31:0]         root_sq;
  logic [3:0]          bit_r;
  logic [TIME_W-1:0]   tr_r, tr_sh;
  logic [FRAC_W-1:0]   tq_r;
  logic [3:0]          tcnt_r;
  logic                ttake;
  logic [ACC_W-1:0]    adot;
  logic [16:0]         ssum;
  logic [15:0]         cpos, tfv;
  logic                go_done;
  out_t                out_r, res;

  assign job_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = out_r;

  always_comb begin
    acc_add  = acc_r + (mb_r[0] ? ma_r : '0);
    rem_sh   = {rem_r[REM_W-2:0], feed_r};
    root_try = root_r | (16'd1 << bit_r);
    root_sq  = 32'(root_try) * 32'(root_try);
    tr_sh    = {tr_r[TIME_W-2:0], 1'b0};
    ttake    = tr_r[TIME_W-1] || (tr_sh >= job_r.window);
    adot     = job_r.dot[DOT_W-1] ? ACC_W'(-job_r.dot) : ACC_W'(job_r.dot);
    mag      = '0;
    if (state_r == S_SQRT) begin
      mag = (root_sq <= 32'(quo_r)) ? root_try : root_r;
    end
    cpos = (!job_r.dot[DOT_W-1] && job_r.time_ok) ? mag : 16'd0;
    tfv  = job_r.time_ok ? 16'(tq_r) : 16'd0;
    ssum = 17'(tfv) + 17'(cpos);
    res.strength    = ssum[16:1];
    res.correlation = job_r.dot[DOT_W-1] ? 16'(16'd0 - mag) : ((mag > Q_MAX) ? Q_MAX : mag);
    res.time_factor = tfv;
    res.too_long    = job_r.too_long;
  end

  always_comb begin
    state_nxt = state_r;
    go_done   = 1'b0;
    unique case (state_r)
      S_IDLE:  if (job_valid) state_nxt = S_MUL_P;
      S_MUL_P: if (step_r == STEP_W'(ACC_W-1)) state_nxt = S_MUL_S;
      S_MUL_S: if (step_r == STEP_W'(ACC_W-1)) begin
        if (p_r == '0 || acc_add == '0) begin
          state_nxt = S_DONE;
          go_done   = 1'b1;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV:   if (step_r == STEP_W'(QUO_W-1)) state_nxt = S_SQRT;
      S_SQRT:  if (bit_r == 4'd0) begin
        state_nxt = S_DONE;
        go_done   = 1'b1;
      end
      S_DONE:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go_done) begin
      out_r <= res;
    end
    if (tcnt_r != 4'd0 && state_r != S_IDLE) begin
      tr_r   <= ttake ? tr_sh - job_r.window : tr_sh;
      tq_r   <= {tq_r[FRAC_W-2:0], ttake};
      tcnt_r <= tcnt_r - 1'b1;
    end
    unique case (state_r)
      S_IDLE: if (job_valid) begin
        job_r  <= job_data;
        ma_r   <= PROD_W'(job_data.cause_norm);
        mb_r   <= job_data.effect_norm;
        acc_r  <= '0;
        step_r <= '0;
        tr_r   <= job_data.window - job_data.lag;
        tq_r   <= '0;
        tcnt_r <= 4'(FRAC_W);
      end
      S_MUL_P: begin
        if (step_r == STEP_W'(ACC_W-1)) begin
          p_r    <= acc_add;
          ma_r   <= PROD_W'(adot);
          mb_r   <= adot;
          acc_r  <= '0;
          step_r <= '0;
        end else begin
          acc_r  <= acc_add;
          ma_r   <= {ma_r[PROD_W-2:0], 1'b0};
          mb_r   <= mb_r >> 1;
          step_r <= step_r + 1'b1;
        end
      end
      S_MUL_S: begin
        if (step_r == STEP_W'(ACC_W-1)) begin
          rem_r  <= REM_W'(acc_add >> 1);
          feed_r <= acc_add[0];
          quo_r  <= '0;
          step_r <= '0;
        end else begin
          acc_r  <= acc_add;
          ma_r   <= {ma_r[PROD_W-2:0], 1'b0};
          mb_r   <= mb_r >> 1;
          step_r <= step_r + 1'b1;
        end
      end
      S_DIV: begin
        feed_r <= 1'b0;
        if (rem_sh >= REM_W'(p_r)) begin
          rem_r <= rem_sh - REM_W'(p_r);
          quo_r <= {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[QUO_W-2:0], 1'b0};
        end
        step_r <= step_r + 1'b1;
        root_r <= '0;
        bit_r  <= 4'd15;
      end
      S_SQRT: begin
        root_r <= mag;
        bit_r  <= bit_r - 1'b1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

endmodule

FILE: hdl/causal_strength_estimator_core.sv
// Causal strength estimator top level: front end, job queue, back end.
// Throughput: one element pair per cycle while the job queue has room. Per run the back
// end does two shift-add multiplies, then a divide and a root unless a product is zero.
// Each run's result occupies the back end; two finished runs may queue behind it.
// Reset (synchronous, rst_n low): accumulators and queue clear, lag window = 1000.
// Depends on csest_pkg, csest_front, csest_fifo, csest_back.
`timescale 1ns / 1ps
module causal_strength_estimator_core import csest_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_data, b_data;

  csest_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .cfg_we, .cfg_wdata,
    .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data)
  );

  csest_fifo u_fifo (
    .clk, .rst_n,
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
  );

  csest_back u_back (
    .clk, .rst_n,
    .job_valid(b_valid), .job_ready(b_ready), .job_data(b_data),
    .out_valid, .out_ready, .out_data
  );

endmodule

FILE: hdl/csest_checker.sv
// Port-level checker for the causal strength estimator, bound to the top level.
// Depends on csest_pkg.
`timescale 1ns / 1ps
module csest_checker import csest_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result request dropped or changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.strength <= 16'd32768 && out_data.time_factor <= 16'd32768)
    else $error("strength or time factor above 1.0");

  a_late: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.time_factor == 16'd0 |-> out_data.strength <= 16'd16384)
    else $error("strength too large with zero time factor");

  a_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.correlation[15]
    |-> out_data.strength == (out_data.time_factor >> 1))
    else $error("negative cosine leaked into strength");

endmodule

bind causal_strength_estimator_core csest_checker u_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_data
);

FILE: bench/tb_causal_strength_estimator_core.sv
// Testbench for causal_strength_estimator_core: directed table, then random vector runs.
// Typed rows check the table, others a strength/cosine predictor. Depends on csest_pkg.
`timescale 1ns / 1ps
module tb_causal_strength_estimator_core;
  import csest_pkg::*;

  localparam int MAX_PAIRS   = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 200;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t res;
  } table_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [TIME_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [TIME_W-1:0] lag_window;
  longint            dot_acc;
  longint unsigned   cause_sq_acc;
  longint unsigned   effect_sq_acc;
  int                pairs_taken;
  bit                run_overflowed;

  out_t              pending_results[$];
  int                errors = 0;
  int                cycles = 0;
  int                send_idle = 0;
  int                recv_idle = 0;
  bit                hold_go = 1'b0;
  bit                hold_done = 1'b0;
  int                hold_left = 0;

  causal_strength_estimator_core #(.MAX_LEN(MAX_PAIRS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // receiver: random stall, one long hold-off on request, check accepted results
  always @(posedge clk) begin
    out_t want;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.strength !== want.strength)
          report("strength", out_data.strength, want.strength);
        if (out_data.correlation !== want.correlation)
          report("correlation", out_data.correlation, want.correlation);
        if (out_data.time_factor !== want.time_factor)
          report("time_factor", out_data.time_factor, want.time_factor);
        if (out_data.too_long !== want.too_long)
          report("too_long", out_data.too_long, want.too_long);
      end
    end
    if (hold_go && !hold_done && hold_left == 0) begin
      hold_left <= 3000;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic int unsigned cosine_mag(longint unsigned adot, longint unsigned cn,
                                             longint unsigned en);
    logic [127:0] norm_prod, dot_side, lhs;
    int unsigned  lo, hi, mid;
    norm_prod = 128'(cn) * 128'(en);
    dot_side  = (128'(adot) * 128'(adot)) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = norm_prod * 128'(mid * mid);
      if (lhs <= dot_side) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic estimate_strength(input in_t r);
    out_t            o;
    int unsigned     mag, tf, cpos;
    longint unsigned adot, lag;
    logic [79:0]     num;
    mag = 0;
    tf = 0;
    cpos = 0;
    o = '0;
    if (r.element_present) begin
      if (pairs_taken < MAX_PAIRS) begin
        dot_acc += longint'(r.cause_element) * longint'(r.effect_element);
        cause_sq_acc += longint'(r.cause_element) * longint'(r.cause_element);
        effect_sq_acc += longint'(r.effect_element) * longint'(r.effect_element);
        pairs_taken++;
      end else begin
        run_overflowed = 1'b1;
      end
    end
    if (!r.last_pair) return;
    if (cause_sq_acc != 0 && effect_sq_acc != 0) begin
      adot = (dot_acc < 0) ? -dot_acc : dot_acc;
      mag = cosine_mag(adot, cause_sq_acc, effect_sq_acc);
      if (dot_acc < 0) begin
        o.correlation = 16'(32'h10000 - mag);
      end else begin
        o.correlation = (mag > 32767) ? Q_MAX : 16'(mag);
        cpos = mag;
      end
    end
    lag = r.effect_time - r.cause_time;
    if (r.effect_time > r.cause_time && lag <= lag_window) begin
      num = 80'(lag_window - lag) << 15;
      tf = int'(num / 80'(lag_window));
    end else begin
      cpos = 0;
    end
    o.strength    = 16'((tf + cpos) >> 1);
    o.time_factor = 16'(tf);
    o.too_long    = run_overflowed;
    pending_results.insert(pending_results.size(), o);
    dot_acc = 0;
    cause_sq_acc = 0;
    effect_sq_acc = 0;
    pairs_taken = 0;
    run_overflowed = 1'b0;
  endtask

  // drive one request; valid stays high into the next request unless we idle
  task automatic send_request(input in_t r);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_window(input logic [TIME_W-1:0] w);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    lag_window = w;
  endtask

  function automatic in_t make_req(input logic [15:0] c, input logic [15:0] e, input bit p,
                                   input logic [63:0] ct, input logic [63:0] et, input bit l);
    in_t r;
    r.cause_element = c;
    r.effect_element = e;
    r.element_present = p;
    r.cause_time = ct;
    r.effect_time = et;
    r.last_pair = l;
    return r;
  endfunction

  function automatic out_t make_res(input logic [15:0] s, input logic [15:0] c,
                                    input logic [15:0] t, input bit tl);
    out_t o;
    o.strength = s;
    o.correlation = c;
    o.time_factor = t;
    o.too_long = tl;
    return o;
  endfunction

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_lag();
    logic [63:0] w;
    w = (lag_window == 0) ? 64'd1 : lag_window;
    case ($urandom_range(9))
      0: return 64'd0;
      1: return w;
      2: return w + 64'd1;
      3: return 64'd1;
      4: return {$urandom, $urandom};
      5: return -64'd1 - 64'($urandom_range(100));
      default: return (w > 64'hFFFF_FFFF) ? {$urandom, $urandom} % w
                                            : 64'($urandom) % (w + 64'd1);
    endcase
  endfunction

  task automatic send_run(input int len, input int absent_pct);
    logic [63:0] ct, et;
    in_t         r;
    ct = {$urandom, $urandom};
    if ($urandom_range(3) == 0) ct = 64'($urandom_range(1000));
    et = ct + rand_lag();
    for (int i = 0; i < len; i++) begin
      r = make_req(rand_elem(), rand_elem(), ($urandom_range(99) >= absent_pct),
                   {$urandom, $urandom}, {$urandom, $urandom}, (i == len - 1));
      if (r.last_pair) begin
        r.cause_time = ct;
        r.effect_time = et;
      end
      send_request(r);
      estimate_strength(r);
    end
  endtask

  initial begin
    table_row_t      rows[$];
    logic [63:0]     windows[5];
    int              len;
    dot_acc = 0;
    cause_sq_acc = 0;
    effect_sq_acc = 0;
    pairs_taken = 0;
    run_overflowed = 1'b0;
    lag_window = TW_RESET;

    rows.insert(rows.size(), table_row_t'{make_req(0, 0, 0, 0, 500, 1), 1,
                                          make_res(8192, 0, 16384, 0)});
    rows.insert(rows.size(), table_row_t'{make_req(16'h7FFF, 16'h7FFF, 1, 10, 10, 1), 1,
                                          make_res(0, 16'h7FFF, 0, 0)});
    rows.insert(rows.size(), table_row_t'{make_req(16'h8000, 16'h7FFF, 1, 0, 1000, 1), 1,
                                          make_res(0, 16'h8000, 0, 0)});
    rows.insert(rows.size(), table_row_t'{make_req(16'h7FFF, 16'h7FFF, 1, 5, 6, 1), 1,
                                          make_res(32751, 16'h7FFF, 32735, 0)});
    rows.insert(rows.size(), table_row_t'{make_req(16'h1234, 0, 1, 0, 7, 1), 1,
                                          make_res(16269, 0, 32538, 0)});
    rows.insert(rows.size(), table_row_t'{make_req(0, 0, 1, 0, 1001, 1), 1,
                                          make_res(0, 0, 0, 0)});
    rows.insert(rows.size(), table_row_t'{make_req(5, 5, 1, '1, 0, 1), 1,
                                          make_res(0, 16'h7FFF, 0, 0)});
    rows.insert(rows.size(), table_row_t'{make_req(5, 5, 1, 0, '1, 1), 1,
                                          make_res(0, 16'h7FFF, 0, 0)});
    rows.insert(rows.size(), table_row_t'{make_req(16'h7FFF, 16'h8000, 0, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), table_row_t'{make_req(16'h0100, 16'h0300, 1, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), table_row_t'{make_req(16'h8000, 16'h0001, 1, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), table_row_t'{make_req(16'h4000, 16'hC000, 1, 100, 350, 1), 0,
                                          '0});
    rows.insert(rows.size(), table_row_t'{make_req(16'h0003, 16'h0004, 1, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), table_row_t'{make_req(16'h0000, 16'h0000, 0, 20, 21, 1), 0,
                                          '0});
    rows.insert(rows.size(), table_row_t'{make_req(16'hFFFF, 16'h0001, 1, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), table_row_t'{make_req(16'h0001, 16'h7FFF, 1, 3, 999, 1), 0,
                                          '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_request(rows[i].req);
      if (rows[i].typed) begin
        estimate_strength(rows[i].req);
        pending_results[pending_results.size() - 1] = rows[i].res;
      end else begin
        estimate_strength(rows[i].req);
      end
    end

    windows = '{64'd0, '1, 64'd1, {$urandom, $urandom}, 64'd100000};
    for (int ph = 0; ph < 5; ph++) begin
      write_window(windows[ph]);
      for (int k = 0; k < 30; k++) begin
        case (k / 10)
          0: begin send_idle = 38; recv_idle = 46; end
          1: begin send_idle = 46; recv_idle = 38; end
          default: begin send_idle = 0; recv_idle = 0; end
        endcase
        if (ph == 2 && k == 25) hold_go = 1'b1;
        if (k == 29 && ph >= 3) len = MAX_PAIRS + $urandom_range(1, 20);
        else if ($urandom_range(9) == 0) len = $urandom_range(10, 30);
        else len = $urandom_range(1, 6);
        send_run(len, ($urandom_range(4) == 0) ? 30 : 5);
      end
    end
    write_window(TW_RESET);
    for (int k = 0; k < 20; k++) send_run($urandom_range(1, 6), 10);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: causal_strength_estimator_core.f
hdl/csest_pkg.sv
hdl/csest_front.sv
hdl/csest_fifo.sv
hdl/csest_back.sv
hdl/causal_strength_estimator_core.sv
hdl/csest_checker.sv
bench/tb_causal_strength_estimator_core.sv
